/* hdl/tkst_pkg.sv */
`timescale 1ns / 1ps

package tkst_pkg;

   localparam int TKST_MAX_K      = 64;
   localparam int TKST_NODE_BITS  = 16;
   localparam int TKST_SCORE_BITS = 32;

   localparam int CSR_BITS  = 7;
   localparam int RANK_BITS = 6;

   localparam logic [CSR_BITS-1:0] K_RESET = 7'd64;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } tkst_mem_ctl_type;

endpackage

/* hdl/tkst_ram.sv */
`timescale 1ns / 1ps

module tkst_ram #(
   parameter  int WIDTH     = 8,
   parameter  int DEPTH     = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tkst_store.sv */
`timescale 1ns / 1ps

module tkst_store #(
   parameter  int MAX_K      = tkst_pkg::TKST_MAX_K,
   parameter  int NODE_BITS  = tkst_pkg::TKST_NODE_BITS,
   parameter  int SCORE_BITS = tkst_pkg::TKST_SCORE_BITS,
   localparam int IDX_BITS   = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tkst_pkg::tkst_mem_ctl_type      mem_ctl,
   input  logic [IDX_BITS-1:0]             rd_addr,
   input  logic [IDX_BITS-1:0]             wr_addr,
   input  logic [NODE_BITS-1:0]            wr_node,
   input  logic [SCORE_BITS-1:0]           wr_score,
   output logic [NODE_BITS-1:0]            rd_node,
   output logic [SCORE_BITS-1:0]           rd_score
);

   import tkst_pkg::*;

   localparam int WIDTH = NODE_BITS + SCORE_BITS;

   logic [MAX_K-1:0] valid_ff;
   logic [MAX_K-1:0] valid_in;
   logic             rd_valid_ff;
   logic             rd_valid_in;
   logic [WIDTH-1:0] ram_rd_data;

   // An entry that has not been written since the last readout reads as zero.
   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (mem_ctl.clear) begin
         valid_in = '0;
      end else if (mem_ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (mem_ctl.rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   tkst_ram #(
      .WIDTH (WIDTH),
      .DEPTH (MAX_K)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_node, wr_score}),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_node  = rd_valid_ff ? ram_rd_data[WIDTH-1:SCORE_BITS] : '0;
   assign rd_score = rd_valid_ff ? ram_rd_data[SCORE_BITS-1:0] : '0;

endmodule

/* hdl/tkst_ctrl.sv */
`timescale 1ns / 1ps

module tkst_ctrl #(
   parameter  int MAX_K      = tkst_pkg::TKST_MAX_K,
   parameter  int NODE_BITS  = tkst_pkg::TKST_NODE_BITS,
   parameter  int SCORE_BITS = tkst_pkg::TKST_SCORE_BITS,
   localparam int IDX_BITS   = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [IDX_BITS-1:0]              k_last,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [NODE_BITS-1:0]             req_node_id,
   input  logic [SCORE_BITS-1:0]            req_score,
   input  logic                             req_last_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tkst_pkg::RANK_BITS-1:0]   rsp_rank,
   output logic [NODE_BITS-1:0]             rsp_best_node,
   output logic [SCORE_BITS-1:0]            rsp_best_score,
   output logic                             rsp_last_of_run,
   output tkst_pkg::tkst_mem_ctl_type       mem_ctl,
   output logic [IDX_BITS-1:0]              rd_addr,
   output logic [IDX_BITS-1:0]              wr_addr,
   output logic [NODE_BITS-1:0]             wr_node,
   output logic [SCORE_BITS-1:0]            wr_score,
   input  logic [NODE_BITS-1:0]             rd_node,
   input  logic [SCORE_BITS-1:0]            rd_score
);

   import tkst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SHIFT,
      S_PUT,
      S_OUT_ISSUE,
      S_OUT_LOAD
   } ctrl_state_type;

   localparam logic [IDX_BITS-1:0] IDX_ONE = IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] IDX_TWO = IDX_BITS'(2);

   ctrl_state_type        state_ff, state_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic                  last_ff, last_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RANK_BITS-1:0]  rsp_rank_ff, rsp_rank_in;
   logic [NODE_BITS-1:0]  rsp_node_ff, rsp_node_in;
   logic [SCORE_BITS-1:0] rsp_score_ff, rsp_score_in;
   logic                  rsp_last_ff, rsp_last_in;
   ctrl_state_type        done_state;

   assign done_state = last_ff ? S_OUT_ISSUE : S_IDLE;

   // The list is walked from the bottom slot upwards, one slot per cycle, with
   // the single comparator deciding whether the slot entry moves down a place.
   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      score_in     = score_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_score_in = rsp_score_ff;
      rsp_last_in  = rsp_last_ff;
      mem_ctl      = '0;
      rd_addr      = idx_ff;
      wr_addr      = idx_ff;
      wr_node      = node_ff;
      wr_score     = score_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               node_in       = req_node_id;
               score_in      = req_score;
               last_in       = req_last_item;
               mem_ctl.rd_en = 1'b1;
               rd_addr       = k_last;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (score_ff > rd_score) begin
               if (k_last == '0) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = '0;
                  idx_in        = '0;
                  state_in      = done_state;
               end else begin
                  idx_in        = k_last;
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = k_last - IDX_ONE;
                  state_in      = S_SHIFT;
               end
            end else begin
               idx_in   = '0;
               state_in = done_state;
            end
         end
         S_SHIFT: begin
            mem_ctl.wr_en = 1'b1;
            if (rd_score < score_ff) begin
               wr_node  = rd_node;
               wr_score = rd_score;
               idx_in   = idx_ff - IDX_ONE;
               if (idx_ff == IDX_ONE) begin
                  state_in = S_PUT;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = idx_ff - IDX_TWO;
               end
            end else begin
               idx_in   = '0;
               state_in = done_state;
            end
         end
         S_PUT: begin
            mem_ctl.wr_en = 1'b1;
            idx_in        = '0;
            state_in      = done_state;
         end
         S_OUT_ISSUE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               mem_ctl.rd_en = 1'b1;
               state_in      = S_OUT_LOAD;
            end
         end
         S_OUT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_rank_in  = RANK_BITS'(idx_ff);
            rsp_node_in  = rd_node;
            rsp_score_in = rd_score;
            rsp_last_in  = (idx_ff == k_last);
            if (idx_ff == k_last) begin
               mem_ctl.clear = 1'b1;
               idx_in        = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_ONE;
               state_in = S_OUT_ISSUE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff      <= node_in;
      score_ff     <= score_in;
      last_ff      <= last_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_score_ff <= rsp_score_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_best_node   = rsp_node_ff;
   assign rsp_best_score  = rsp_score_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

/* hdl/top_k_score_tracker_unit.sv */
// A transaction that does not qualify is dropped after one compare with the bottom slot;
// one that enters the list is walked upwards one slot per cycle through the shared
// comparator and the single read and write port of the slot memory. A new transaction is
// taken only once the last one is done. A final transaction reads out k results, each
// fetched and registered in turn, a result held until the consumer takes it. Reset clears
// the valid bits, sets k to 64 and empties the output register; there is no clearing pass.
`timescale 1ns / 1ps

module top_k_score_tracker_unit #(
   parameter  int MAX_K      = tkst_pkg::TKST_MAX_K,
   parameter  int NODE_BITS  = tkst_pkg::TKST_NODE_BITS,
   parameter  int SCORE_BITS = tkst_pkg::TKST_SCORE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [NODE_BITS-1:0]             req_node_id,
   input  logic [SCORE_BITS-1:0]            req_score,
   input  logic                             req_last_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tkst_pkg::RANK_BITS-1:0]   rsp_rank,
   output logic [NODE_BITS-1:0]             rsp_best_node,
   output logic [SCORE_BITS-1:0]            rsp_best_score,
   output logic                             rsp_last_of_run,
   input  logic                             csr_wr_en,
   input  logic [tkst_pkg::CSR_BITS-1:0]    csr_wr_data
);

   import tkst_pkg::*;

   localparam int IDX_BITS = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam logic [CSR_BITS-1:0] MAX_K_CSR = CSR_BITS'(MAX_K);

   logic [CSR_BITS-1:0]   k_in_use_ff, k_in_use_in;
   logic [IDX_BITS-1:0]   k_last;
   tkst_mem_ctl_type      mem_ctl;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [NODE_BITS-1:0]  wr_node;
   logic [SCORE_BITS-1:0] wr_score;
   logic [NODE_BITS-1:0]  rd_node;
   logic [SCORE_BITS-1:0] rd_score;

   assign k_in_use_in = csr_wr_en ? csr_wr_data : k_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_in_use_ff <= K_RESET;
      end else begin
         k_in_use_ff <= k_in_use_in;
      end
   end

   // A count of zero is treated as one, and anything above the slot count as the slot count.
   always_comb begin
      if (k_in_use_ff == '0) begin
         k_last = '0;
      end else if (k_in_use_ff > MAX_K_CSR) begin
         k_last = IDX_BITS'(MAX_K - 1);
      end else begin
         k_last = IDX_BITS'(k_in_use_ff - 1'b1);
      end
   end

   tkst_ctrl #(
      .MAX_K      (MAX_K),
      .NODE_BITS  (NODE_BITS),
      .SCORE_BITS (SCORE_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .k_last          (k_last),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_node_id     (req_node_id),
      .req_score       (req_score),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rank        (rsp_rank),
      .rsp_best_node   (rsp_best_node),
      .rsp_best_score  (rsp_best_score),
      .rsp_last_of_run (rsp_last_of_run),
      .mem_ctl         (mem_ctl),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr),
      .wr_node         (wr_node),
      .wr_score        (wr_score),
      .rd_node         (rd_node),
      .rd_score        (rd_score)
   );

   tkst_store #(
      .MAX_K      (MAX_K),
      .NODE_BITS  (NODE_BITS),
      .SCORE_BITS (SCORE_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .mem_ctl  (mem_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_node  (wr_node),
      .wr_score (wr_score),
      .rd_node  (rd_node),
      .rd_score (rd_score)
   );

endmodule

/* hdl/tkst_checker.sv */
`timescale 1ns / 1ps

module tkst_checker #(
   parameter  int NODE_BITS  = tkst_pkg::TKST_NODE_BITS,
   parameter  int SCORE_BITS = tkst_pkg::TKST_SCORE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [tkst_pkg::RANK_BITS-1:0]   rsp_rank,
   input  logic [NODE_BITS-1:0]             rsp_best_node,
   input  logic [SCORE_BITS-1:0]            rsp_best_score,
   input  logic                             rsp_last_of_run
);

   import tkst_pkg::*;

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rank)
         && $stable(rsp_best_node) && $stable(rsp_best_score) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // No new transaction is taken while a readout is still in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("input accepted during readout");

   // Ready drops once a transaction is accepted, as the block leaves its idle state.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready did not drop after a transaction");

   // Within a readout each slot is fetched afresh, so a taken result leaves a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> !rsp_valid)
      else $error("readout result appeared without a fetch cycle");

endmodule

bind top_k_score_tracker_unit tkst_checker #(
   .NODE_BITS  (NODE_BITS),
   .SCORE_BITS (SCORE_BITS)
) u_tkst_checker (.*);

/* bench/top_k_score_tracker_checker.sv */
`timescale 1ns / 1ps

module top_k_score_tracker_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [tkst_pkg::TKST_NODE_BITS-1:0]  req_node_id,
   input  logic [tkst_pkg::TKST_SCORE_BITS-1:0] req_score,
   input  logic                                req_last_item,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [tkst_pkg::RANK_BITS-1:0]       rsp_rank,
   input  logic [tkst_pkg::TKST_NODE_BITS-1:0]  rsp_best_node,
   input  logic [tkst_pkg::TKST_SCORE_BITS-1:0] rsp_best_score,
   input  logic                                rsp_last_of_run,
   input  logic                                csr_wr_en,
   input  logic [tkst_pkg::CSR_BITS-1:0]        csr_wr_data,
   output int                                  mismatch_count,
   output int                                  pending_count
);

   import tkst_pkg::*;

   typedef struct packed {
      logic [RANK_BITS-1:0]       rank;
      logic [TKST_NODE_BITS-1:0]  node;
      logic [TKST_SCORE_BITS-1:0] score;
      logic                       last;
   } ranked_entry_type;

   logic [TKST_SCORE_BITS-1:0] slot_score [TKST_MAX_K];
   logic [TKST_NODE_BITS-1:0]  slot_node  [TKST_MAX_K];
   logic [CSR_BITS-1:0]        k_setting;
   ranked_entry_type           readout_q [$];

   // A setting of zero keeps one slot, and anything above the slot count keeps all of them.
   function automatic int slots_in_play();
      if (k_setting == '0) begin
         return 1;
      end
      if (k_setting > TKST_MAX_K) begin
         return TKST_MAX_K;
      end
      return int'(k_setting);
   endfunction

   task automatic clear_slots();
      foreach (slot_score[i]) begin
         slot_score[i] = '0;
         slot_node[i]  = '0;
      end
   endtask

   // The candidate settles below every slot whose score is at least its own, so ties keep
   // the earlier node ahead; only the first k slots move.
   task automatic admit_candidate(input logic [TKST_NODE_BITS-1:0] node,
                                  input logic [TKST_SCORE_BITS-1:0] score,
                                  input int k);
      int pos;
      int i;
      pos = 0;
      if (score > slot_score[k-1]) begin
         while (pos < k - 1 && slot_score[pos] >= score) begin
            pos++;
         end
         for (i = k - 1; i > pos; i--) begin
            slot_score[i] = slot_score[i-1];
            slot_node[i]  = slot_node[i-1];
         end
         slot_score[pos] = score;
         slot_node[pos]  = node;
      end
   endtask

   task automatic queue_readout(input int k);
      ranked_entry_type entry;
      int i;
      for (i = 0; i < k; i++) begin
         entry.rank  = RANK_BITS'(i);
         entry.node  = slot_node[i];
         entry.score = slot_score[i];
         entry.last  = (i == k - 1);
         readout_q.push_back(entry);
      end
      clear_slots();
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      ranked_entry_type want;
      if (reset) begin
         clear_slots();
         k_setting = K_RESET;
         readout_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readout_q.size() == 0) begin
               $error("unexpected result transaction: rank %0d, node %0h, score %0h",
                      rsp_rank, rsp_best_node, rsp_best_score);
               mismatch_count++;
            end else begin
               want = readout_q.pop_front();
               check_field("rank", 64'(want.rank), 64'(rsp_rank));
               check_field("best_node", 64'(want.node), 64'(rsp_best_node));
               check_field("best_score", 64'(want.score), 64'(rsp_best_score));
               check_field("last_of_run", 64'(want.last), 64'(rsp_last_of_run));
            end
         end
         if (csr_wr_en) begin
            k_setting = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            admit_candidate(req_node_id, req_score, slots_in_play());
            if (req_last_item) begin
               queue_readout(slots_in_play());
            end
         end
      end
      pending_count = readout_q.size();
   end

endmodule

/* bench/top_k_score_tracker_unit_test.sv */
`timescale 1ns / 1ps

module top_k_score_tracker_unit_test;

   import tkst_pkg::*;

   localparam int RANDOM_ITEMS  = 260;
   localparam int SETTLE_CYCLES = 80;
   localparam int LIMIT_CYCLES  = 1500000;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic [TKST_NODE_BITS-1:0]  req_node_id   = '0;
   logic [TKST_SCORE_BITS-1:0] req_score     = '0;
   logic                       req_last_item = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [RANK_BITS-1:0]       rsp_rank;
   logic [TKST_NODE_BITS-1:0]  rsp_best_node;
   logic [TKST_SCORE_BITS-1:0] rsp_best_score;
   logic                       rsp_last_of_run;
   logic                       csr_wr_en     = 1'b0;
   logic [CSR_BITS-1:0]        csr_wr_data   = '0;

   int             mismatch_count;
   int             pending_count;
   int             cycle_count = 0;
   int             burst_left  = 0;
   int             ready_left  = 0;
   ready_mode_type ready_mode  = READY_ALWAYS;

   top_k_score_tracker_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_node_id     (req_node_id),
      .req_score       (req_score),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rank        (rsp_rank),
      .rsp_best_node   (rsp_best_node),
      .rsp_best_score  (rsp_best_score),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   top_k_score_tracker_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_node_id     (req_node_id),
      .req_score       (req_score),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rank        (rsp_rank),
      .rsp_best_node   (rsp_best_node),
      .rsp_best_score  (rsp_best_score),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(4, 40);
      end
      ready_left--;
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         READY_SPARSE: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= (ready_left % 7 == 0);
         end
      endcase
   end

   task automatic send_candidate(input logic [TKST_NODE_BITS-1:0] node,
                                 input logic [TKST_SCORE_BITS-1:0] score,
                                 input logic last);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 6);
      end
      req_node_id   <= node;
      req_score     <= score;
      req_last_item <= last;
      req_valid     <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
      end
   endtask

   // The block may still be placing the last candidate when no readout transaction is pending.
   task automatic quiesce();
      if (burst_left != 0) begin
         req_valid  <= 1'b0;
         burst_left = 0;
      end
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_k(input logic [CSR_BITS-1:0] value);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [TKST_SCORE_BITS-1:0] pick_score();
      case ($urandom_range(0, 5))
         0: begin
            return 32'($urandom_range(0, 3));
         end
         1: begin
            return 32'($urandom_range(0, 7)) << 16;
         end
         2, 3: begin
            return 32'($urandom());
         end
         4: begin
            return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
         end
         default: begin
            return 32'($urandom_range(0, 1000));
         end
      endcase
   endfunction

   initial begin
      int                  random_items;
      int                  phase_len;
      int                  i;
      logic                with_readout;
      logic [CSR_BITS-1:0] k_value;
      random_items = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // At the reset setting a zero score never enters and ties keep the earlier node ahead.
      send_candidate(16'h0001, 32'h0000_0000, 1'b0);
      send_candidate(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      send_candidate(16'h0002, 32'h0001_0000, 1'b0);
      send_candidate(16'h0003, 32'h0001_0000, 1'b0);
      send_candidate(16'h0000, 32'h0000_0001, 1'b0);
      send_candidate(16'h0004, 32'hFFFF_FFFF, 1'b1);

      set_k(7'd1);
      send_candidate(16'h0005, 32'd10, 1'b0);
      send_candidate(16'h0006, 32'd10, 1'b0);
      send_candidate(16'h0007, 32'd9, 1'b0);
      send_candidate(16'h0008, 32'd11, 1'b1);

      set_k(7'd0);
      send_candidate(16'h0009, 32'd0, 1'b1);

      set_k(7'd127);
      send_candidate(16'h000A, 32'd5, 1'b0);
      send_candidate(16'h000B, 32'd7, 1'b1);

      // Shrinking k mid-run must leave the slots beyond it untouched until the readout.
      set_k(7'd8);
      send_candidate(16'h0100, 32'd100, 1'b0);
      send_candidate(16'h0200, 32'd200, 1'b0);
      send_candidate(16'h0300, 32'd300, 1'b0);
      send_candidate(16'h0400, 32'd400, 1'b0);
      set_k(7'd3);
      send_candidate(16'h0250, 32'd250, 1'b0);
      send_candidate(16'h0050, 32'd50, 1'b0);
      set_k(7'd8);
      send_candidate(16'h0001, 32'd1, 1'b1);

      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               k_value = 7'd0;
            end
            1: begin
               k_value = 7'd1;
            end
            2: begin
               k_value = 7'd64;
            end
            3: begin
               k_value = 7'd127;
            end
            4, 5: begin
               k_value = 7'($urandom_range(2, 6));
            end
            default: begin
               k_value = 7'($urandom_range(0, 127));
            end
         endcase
         set_k(k_value);
         phase_len    = $urandom_range(1, 24);
         with_readout = ($urandom_range(0, 6) != 0);
         for (i = 0; i < phase_len; i++) begin
            send_candidate(16'($urandom_range(0, 65535)), pick_score(),
                           with_readout && (i == phase_len - 1));
            random_items++;
         end
      end

      quiesce();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* top_k_score_tracker_unit.f */
hdl/tkst_pkg.sv
hdl/tkst_ram.sv
hdl/tkst_store.sv
hdl/tkst_ctrl.sv
hdl/top_k_score_tracker_unit.sv
hdl/tkst_checker.sv
bench/top_k_score_tracker_checker.sv
bench/top_k_score_tracker_unit_test.sv
